>>> sv/amx_pkg.sv
// Shared types, constants and helpers for the accumulator machine executor.
package amx_pkg;

  localparam int unsigned MEM_DEPTH_DEF = 128;
  localparam int unsigned OQ_DEPTH      = 3;
  localparam int unsigned OQ_PW         = 2;
  localparam int unsigned OQ_CW         = 2;

  typedef enum logic [3:0] {
    OP_SET   = 4'd0,
    OP_LDR   = 4'd1,
    OP_ADD1  = 4'd2,
    OP_ADD2  = 4'd3,
    OP_ADD3  = 4'd4,
    OP_INC   = 4'd5,
    OP_DEC   = 4'd6,
    OP_STR   = 4'd7,
    OP_SHW   = 4'd8,
    OP_END   = 4'd9,
    OP_PAUSE = 4'd10
  } op_e;

  localparam logic [1:0] SEL_MEM  = 2'd0;
  localparam logic [1:0] SEL_ACC  = 2'd1;
  localparam logic [1:0] SEL_AREG = 2'd2;

  // reduce a 7-bit address into the memory range by repeated subtraction
  function automatic logic [6:0] slot_f(input logic [6:0] addr, input int unsigned depth);
    logic [6:0] v;
    v = addr;
    for (int i = 0; i < 8; i++) begin
      if (32'(v) >= depth) begin
        v = v - 7'(depth);
      end
    end
    return v;
  endfunction

endpackage

>>> sv/accumulator_machine_executor.sv
// Accumulator machine executor top level: fetch/read stage, execute/write stage.
// A shown item passes the execute stage register and then the output queue.
// Throughput: one instruction per cycle while s_axis_tready is high; the memory reads
// both operands in the accept cycle and the execute stage writes back in the next,
// with forwarding between them. Reset: asynchronous; afterwards the word memory is
// cleared one word a cycle, during which s_axis_tready stays low.
module accumulator_machine_executor
  import amx_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] operation, [10:4] addr_a, [17:11] addr_b, [24:18] addr_dest,
  // [56:25] immediate, [58:57] show_target, [63:59] zero
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] shown_value
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  logic             accept;
  logic [AW-1:0]    in_a, in_b, in_d;
  logic             mem_busy;
  logic [31:0]      rd_a, rd_b;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [31:0]      wdata;
  logic [OQ_CW-1:0] oq_count;
  logic             push;
  logic [31:0]      push_data;
  logic             exec;
  logic [31:0]      op_a, op_b;

  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [AW-1:0]    s1_a_q, s1_d_q;
  logic [31:0]      s1_imm_q;
  logic [1:0]       s1_sel_q;
  logic             fwd_a_q, fwd_b_q;
  logic [31:0]      fwd_data_q;

  logic [31:0]      acc_q, acc_d;
  logic [15:0]      areg_q, areg_d;
  logic [15:0]      pc_q, pc_d;
  logic             halted_q, halted_d;

  assign in_a = AW'(slot_f(s_axis_tdata[10:4], MEM_DEPTH));
  assign in_b = AW'(slot_f(s_axis_tdata[17:11], MEM_DEPTH));
  assign in_d = AW'(slot_f(s_axis_tdata[24:18], MEM_DEPTH));

  assign s_axis_tready = !mem_busy && ((3'(oq_count) + 3'(s1_valid_q)) <= 3'(OQ_DEPTH - 1));
  assign accept        = s_axis_tvalid & s_axis_tready;

  amx_wmem #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_wmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (in_a),
    .raddr_b_i (in_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b),
    .busy_o    (mem_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
      areg_q     <= '0;
      pc_q       <= '0;
      halted_q   <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      acc_q      <= acc_d;
      areg_q     <= areg_d;
      pc_q       <= pc_d;
      halted_q   <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= op_e'(s_axis_tdata[3:0]);
      s1_a_q   <= in_a;
      s1_d_q   <= in_d;
      s1_imm_q <= s_axis_tdata[56:25];
      s1_sel_q <= s_axis_tdata[58:57];
    end
    fwd_a_q    <= we && (waddr == in_a);
    fwd_b_q    <= we && (waddr == in_b);
    fwd_data_q <= wdata;
  end

  assign op_a = fwd_a_q ? fwd_data_q : rd_a;
  assign op_b = fwd_b_q ? fwd_data_q : rd_b;
  assign exec = s1_valid_q && !halted_q;

  always_comb begin
    acc_d     = acc_q;
    areg_d    = areg_q;
    pc_d      = pc_q;
    halted_d  = halted_q;
    we        = 1'b0;
    waddr     = s1_a_q;
    wdata     = s1_imm_q;
    push      = 1'b0;
    push_data = op_a;
    if (exec) begin
      areg_d = pc_q;
      pc_d   = pc_q + 16'd1;
      unique case (s1_op_q)
        OP_SET: begin
          we = 1'b1;
        end
        OP_LDR: begin
          acc_d  = op_a;
          areg_d = 16'(s1_a_q);
        end
        OP_ADD1: begin
          acc_d = acc_q + op_a;
        end
        OP_ADD2: begin
          acc_d = op_a + op_b;
        end
        OP_ADD3: begin
          we    = 1'b1;
          waddr = s1_d_q;
          wdata = op_a + op_b;
        end
        OP_INC: begin
          we    = 1'b1;
          wdata = op_a + 32'd1;
        end
        OP_DEC: begin
          we    = 1'b1;
          wdata = op_a - 32'd1;
        end
        OP_STR: begin
          we    = 1'b1;
          wdata = acc_q;
        end
        OP_SHW: begin
          push = 1'b1;
          case (s1_sel_q)
            SEL_ACC:  push_data = acc_q;
            SEL_AREG: push_data = {16'd0, pc_q};
            default:  push_data = op_a;
          endcase
        end
        OP_END: begin
          halted_d = 1'b1;
          pc_d     = pc_q;
        end
        default: begin
        end
      endcase
    end
  end

  amx_oq u_oq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_data_i   (push_data),
    .count_o       (oq_count),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_oq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (32'(oq_count) < OQ_DEPTH) || m_axis_tready)
    else $error("output queue overflow");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt state cleared without reset");

  a_pc_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && s1_op_q != OP_END) |=> pc_q == $past(pc_q) + 16'd1)
    else $error("program counter did not advance");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !accept && !s1_valid_q)
    else $error("instruction in flight during memory clear");
`endif

endmodule

>>> sv/amx_wmem.sv
// Word memory: two registered read ports, one write port, clear sweep after reset.
module amx_wmem
  import amx_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int unsigned AW        = $clog2(MEM_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [31:0]   rdata_a_o,
  output logic [31:0]   rdata_b_o,
  output logic          busy_o
);

  logic [31:0]   mem [MEM_DEPTH];
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (32'(clr_addr_q) == MEM_DEPTH - 1) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign wr_en   = clr_q | we_i;
  assign wr_addr = clr_q ? clr_addr_q : waddr_i;
  assign wr_data = clr_q ? 32'd0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

  assign busy_o = clr_q;

endmodule

>>> sv/amx_oq.sv
// Output item queue of three entries feeding the master stream.
module amx_oq
  import amx_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [31:0]      push_data_i,
  output logic [OQ_CW-1:0] count_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata
);

  logic [31:0]      entry [OQ_DEPTH];
  logic [OQ_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OQ_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OQ_CW-1:0] count_q, count_d;
  logic             pop;

  assign pop = m_axis_tvalid & m_axis_tready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == OQ_DEPTH - 1) ? '0 : wr_ptr_q + OQ_PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == OQ_DEPTH - 1) ? '0 : rd_ptr_q + OQ_PW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + OQ_CW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - OQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry[wr_ptr_q] <= push_data_i;
    end
  end

  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = entry[rd_ptr_q];
  assign count_o       = count_q;

endmodule

>>> sim/tb_accumulator_machine_executor.sv
// Self-checking testbench for the accumulator machine executor with a built-in instruction model.
`timescale 1ns / 100ps

module tb_accumulator_machine_executor
  import amx_pkg::*;
;

  localparam int unsigned DEPTH       = MEM_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RAND_ITEMS  = 700;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic [31:0] word_mdl [DEPTH];
  logic [31:0] acc_mdl;
  logic [15:0] areg_mdl;
  logic [15:0] pc_mdl;
  logic        halted_mdl;

  logic [31:0] shown_q [$];
  logic [31:0] want_val;
  int unsigned err_count   = 0;
  int unsigned instr_count = 0;
  int unsigned shown_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  int unsigned rx_roll;
  bit          tx_burst    = 1'b0;
  bit          rx_free     = 1'b0;

  accumulator_machine_executor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] pack_instr(logic [3:0] op, logic [6:0] a, logic [6:0] b,
                                             logic [6:0] d, logic [31:0] imm, logic [1:0] sel);
    return {5'b0, sel, imm, d, b, a, op};
  endfunction

  function automatic logic [6:0] word_slot(logic [6:0] addr);
    return 7'(32'(addr) % DEPTH);
  endfunction

  task automatic expect_shown(input logic [31:0] v);
    shown_q = {shown_q, v};
  endtask

  task automatic execute_instr(input logic [63:0] w);
    logic [3:0]  op;
    logic [6:0]  a;
    logic [6:0]  b;
    logic [6:0]  d;
    logic [31:0] imm;
    logic [1:0]  sel;
    op  = w[3:0];
    a   = word_slot(w[10:4]);
    b   = word_slot(w[17:11]);
    d   = word_slot(w[24:18]);
    imm = w[56:25];
    sel = w[58:57];
    if (halted_mdl) return;
    areg_mdl = pc_mdl;
    case (op)
      OP_SET:  word_mdl[a] = imm;
      OP_LDR: begin
        acc_mdl  = word_mdl[a];
        areg_mdl = 16'(a);
      end
      OP_ADD1: acc_mdl = acc_mdl + word_mdl[a];
      OP_ADD2: acc_mdl = word_mdl[a] + word_mdl[b];
      OP_ADD3: word_mdl[d] = word_mdl[a] + word_mdl[b];
      OP_INC:  word_mdl[a] = word_mdl[a] + 32'd1;
      OP_DEC:  word_mdl[a] = word_mdl[a] - 32'd1;
      OP_STR:  word_mdl[a] = acc_mdl;
      OP_SHW: begin
        case (sel)
          SEL_ACC:  expect_shown(acc_mdl);
          SEL_AREG: expect_shown({16'b0, areg_mdl});
          default:  expect_shown(word_mdl[a]);
        endcase
      end
      OP_END: begin
        halted_mdl = 1'b1;
        return;
      end
      default: ;
    endcase
    pc_mdl = pc_mdl + 16'd1;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_instr(input logic [3:0] op, input logic [6:0] a, input logic [6:0] b,
                             input logic [6:0] d, input logic [31:0] imm, input logic [1:0] sel);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_instr(op, a, b, d, imm, sel);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (shown_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // predict first so that a result of the item accepted at this edge is already queued
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      execute_instr(s_axis_tdata);
      instr_count++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      shown_count++;
      if (shown_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected item, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want_val = shown_q.pop_front();
        if (m_axis_tdata !== want_val) begin
          err_count++;
          $display("%0t: shown_value mismatch, expected %h, actual %h",
                   $time, want_val, m_axis_tdata);
        end
      end
    end
    if (rx_free) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 4) begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(8, 30);
      end else if (rx_roll < 25) begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("[accumulator_machine_executor] ERROR");
        $finish;
      end
    end
  end

  task automatic test_reset_state();
    issue_instr(OP_SHW, 7'd127, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd0, 7'd0, 7'd0, 32'd0, SEL_ACC);
    issue_instr(OP_SHW, 7'd0, 7'd0, 7'd0, 32'd0, SEL_AREG);
  endtask

  task automatic test_store_ops();
    issue_instr(OP_SET, 7'd0, 7'd0, 7'd0, 32'h7fff_ffff, SEL_MEM);
    issue_instr(OP_INC, 7'd0, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SET, 7'd127, 7'd0, 7'd0, 32'h8000_0000, SEL_MEM);
    issue_instr(OP_DEC, 7'd127, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SET, 7'd1, 7'd0, 7'd0, 32'hffff_ffff, SEL_MEM);
    issue_instr(OP_INC, 7'd1, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_DEC, 7'd2, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd0, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd127, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd2, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_LDR, 7'd127, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_STR, 7'd3, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd3, 7'd0, 7'd0, 32'd0, 2'd3);
  endtask

  task automatic test_add_forms();
    issue_instr(OP_ADD1, 7'd0, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_ADD2, 7'd127, 7'd2, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd0, 7'd0, 7'd0, 32'd0, SEL_ACC);
    issue_instr(OP_ADD3, 7'd0, 7'd127, 7'd126, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd126, 7'd0, 7'd0, 32'd0, SEL_MEM);
  endtask

  task automatic test_unknown_ops();
    issue_instr(4'd11, 7'd5, 7'd5, 7'd5, 32'hdead_beef, SEL_ACC);
    issue_instr(4'd15, 7'd127, 7'd127, 7'd127, 32'hffff_ffff, 2'd3);
    issue_instr(OP_PAUSE, 7'd0, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd0, 7'd0, 7'd0, 32'd0, SEL_AREG);
  endtask

  task automatic test_random();
    logic [3:0]  op;
    logic [31:0] imm;
    int unsigned r;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_free  <= ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op = 4'($urandom_range(11, 15));
      end else if (r < 20) begin
        op = OP_SHW;
      end else begin
        op = 4'($urandom_range(0, 9));
        if (op == OP_END) op = OP_PAUSE;
      end
      r = $urandom_range(0, 99);
      case (r % 8)
        0: imm = 32'h7fff_ffff;
        1: imm = 32'h8000_0000;
        2: imm = 32'hffff_ffff;
        default: imm = $urandom;
      endcase
      if (r >= 16) imm = $urandom;
      issue_instr(op,
                  ($urandom_range(0, 99) < 60) ? 7'($urandom_range(0, 7)) : 7'($urandom),
                  ($urandom_range(0, 99) < 60) ? 7'($urandom_range(0, 7)) : 7'($urandom),
                  ($urandom_range(0, 99) < 60) ? 7'($urandom_range(0, 7)) : 7'($urandom),
                  imm, 2'($urandom));
    end
    tx_burst = 1'b0;
    rx_free  <= 1'b0;
  endtask

  task automatic test_halt();
    issue_instr(OP_END, 7'd0, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd0, 7'd0, 7'd0, 32'd0, SEL_ACC);
    issue_instr(OP_SET, 7'd0, 7'd0, 7'd0, 32'h1234_5678, SEL_MEM);
    issue_instr(OP_SHW, 7'd0, 7'd0, 7'd0, 32'd0, SEL_MEM);
    issue_instr(OP_SHW, 7'd0, 7'd0, 7'd0, 32'd0, SEL_AREG);
  endtask

  initial begin
    foreach (word_mdl[i]) word_mdl[i] = '0;
    acc_mdl    = '0;
    areg_mdl   = '0;
    pc_mdl     = '0;
    halted_mdl = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_store_ops();
    test_add_forms();
    test_unknown_ops();
    test_random();
    test_halt();
    wait_idle();
    $display("Ran %0d instructions (all operations, unknown codes, wrapping values, halt);",
             instr_count);
    $display("checked %0d shown values under random source gaps and sink stalls.", shown_count);
    if (err_count == 0) begin
      $display("[accumulator_machine_executor] OK");
    end else begin
      $display("[accumulator_machine_executor] ERROR");
    end
    $finish;
  end

endmodule
